// File: rtl/core/pdh_pkg.sv
`default_nettype none
package pdh_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TAKE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT     = 2'd1;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              pin_level;
		logic [TIME_W-1:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic present_out;
		logic event_taken;
		logic event_pending;
	} out_word_t;

	typedef struct packed {
		logic [TIME_W-1:0] debounce_limit;
		logic [TIME_W-1:0] hold_limit;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/presence_debounce_hold_top.sv
// Debounced presence detector with hold timer. Each input word carries a command
// (sample, take event, restart), a raw pin level and a free-running millisecond
// stamp that may wrap. A sample believes a new raw level once it has been steady
// for debounce_limit ms; presence follows the believed level high at once and
// falls only hold_limit ms after the last believed high. A presence change on a
// sample sets a sticky event bit that a take-event word reports and clears. Every
// input word gives exactly one result word. The block takes one word per clock
// while the output side is not stalling: a word waits in the input register, is
// evaluated against the state by two 32-bit subtract-and-compare paths, and
// lands in the output register, which presents its result. Limits must be
// written by the user through the config port only while no word is in flight;
// the block does not enforce this. Both limits reset to zero.
`default_nettype none
module presence_debounce_hold_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input word channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire pdh_pkg::in_word_t              in_word,
	// result word channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output pdh_pkg::out_word_t                  out_word,
	// config write port, index 0 debounce limit, 1 hold limit
	input  wire logic                           cfg_we,
	input  wire logic [pdh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pdh_pkg::*;

	cfg_t     cfg;
	logic     advance;
	logic     valid_s1;
	in_word_t word_s1;

	// limit registers
	pdh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register, refills whenever it is empty or the evaluation stage moves
	pdh_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	// state update and result register
	pdh_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

// File: rtl/core/pdh_cfg_regs.sv
`default_nettype none
module pdh_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pdh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdh_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output pdh_pkg::cfg_t                       cfg
);
	import pdh_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= cfg_wdata[TIME_W-1:0];
				REG_HOLD_LIMIT:     cfg_q.hold_limit     <= cfg_wdata[TIME_W-1:0];
				default:            ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: rtl/core/pdh_in_stage.sv
`default_nettype none
module pdh_in_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire pdh_pkg::in_word_t in_word,
	input  wire logic        advance,
	output logic             valid_s1,
	output pdh_pkg::in_word_t word_s1
);
	import pdh_pkg::*;

	logic valid_q;
	in_word_t word_q;

	assign in_ready = !valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= in_word;
		end
	end

	assign valid_s1 = valid_q;
	assign word_s1  = word_q;

endmodule
`default_nettype wire

// File: rtl/core/pdh_eval.sv
`default_nettype none
module pdh_eval (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire pdh_pkg::cfg_t     cfg,
	input  wire logic         valid_s1,
	input  wire pdh_pkg::in_word_t word_s1,
	output logic              advance,
	output logic              out_valid,
	input  wire logic         out_ready,
	output pdh_pkg::out_word_t out_word
);
	import pdh_pkg::*;

	logic              raw_level_q, raw_level_n;
	logic [TIME_W-1:0] raw_stamp_q, raw_stamp_n;
	logic              stable_level_q, stable_level_n;
	logic              present_q, present_n;
	logic [TIME_W-1:0] high_stamp_q, high_stamp_n;
	logic              change_q, change_n;
	logic              taken_n;
	logic [TIME_W-1:0] raw_age, high_age;
	logic              out_valid_q;
	out_word_t         out_word_q;

	assign advance = !out_valid_q || out_ready;

	// two age compares against the limits, mod 2^32
	assign raw_age  = word_s1.now_ms - raw_stamp_n;
	assign high_age = word_s1.now_ms - high_stamp_q;

	always_comb begin
		raw_level_n    = raw_level_q;
		raw_stamp_n    = raw_stamp_q;
		stable_level_n = stable_level_q;
		present_n      = present_q;
		high_stamp_n   = high_stamp_q;
		change_n       = change_q;
		taken_n        = 1'b0;
		case (word_s1.cmd)
			CMD_SAMPLE: begin
				if (word_s1.pin_level != raw_level_q) begin
					raw_level_n = word_s1.pin_level;
					raw_stamp_n = word_s1.now_ms;
				end
				if (raw_age >= cfg.debounce_limit) begin
					stable_level_n = raw_level_n;
				end
				if (stable_level_n) begin
					high_stamp_n = word_s1.now_ms;
					present_n    = 1'b1;
				end else if (present_q && (high_age >= cfg.hold_limit)) begin
					present_n = 1'b0;
				end
				if (present_n != present_q) begin
					change_n = 1'b1;
				end
			end
			CMD_TAKE: begin
				if (change_q) begin
					taken_n  = 1'b1;
					change_n = 1'b0;
				end
			end
			CMD_RESTART: begin
				raw_stamp_n    = word_s1.now_ms;
				high_stamp_n   = word_s1.now_ms;
				raw_level_n    = 1'b0;
				stable_level_n = 1'b0;
				present_n      = 1'b0;
				change_n       = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_level_q    <= 1'b0;
			raw_stamp_q    <= '0;
			stable_level_q <= 1'b0;
			present_q      <= 1'b0;
			high_stamp_q   <= '0;
			change_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				raw_level_q    <= raw_level_n;
				raw_stamp_q    <= raw_stamp_n;
				stable_level_q <= stable_level_n;
				present_q      <= present_n;
				high_stamp_q   <= high_stamp_n;
				change_q       <= change_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_word_q.present_out   <= present_n;
			out_word_q.event_taken   <= taken_n;
			out_word_q.event_pending <= change_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
`default_nettype wire

// File: rtl/core/pdh_checker.sv
`default_nettype none
module pdh_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire pdh_pkg::in_word_t  in_word,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire pdh_pkg::out_word_t out_word
);
	import pdh_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// a waiting input holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_word))
		else $error("input word dropped while waiting");

	// a taken event clears the sticky flag
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.event_taken |-> !out_word.event_pending)
		else $error("event still pending after take");

	// an empty output register never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind presence_debounce_hold_top pdh_checker u_pdh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
`default_nettype wire
